### rtl/fhp_pkg.sv
// ----------------------------------------------------------------------------
// fhp_pkg
// Shared types, codes and lookup functions for the frame header parser.
// ----------------------------------------------------------------------------
package fhp_pkg;

    // configuration port
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 20;

    localparam logic [CFG_INDEX_W-1:0] CFG_STREAM_RATE            = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_STREAM_BITS_PER_SAMPLE = 1'b1;

    // result error codes
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_SYNC     = 3'd1;
    localparam logic [2:0] ERR_UTF8     = 3'd2;
    localparam logic [2:0] ERR_RSV_BS   = 3'd3;
    localparam logic [2:0] ERR_RSV_RATE = 3'd4;
    localparam logic [2:0] ERR_TRUNC    = 3'd5;
    localparam logic [2:0] ERR_CRC      = 3'd6;

    // header code fields as captured from bytes 1 to 3
    typedef struct packed {
        logic [3:0] bs_code;
        logic [3:0] sr_code;
        logic [3:0] chan;
        logic [2:0] ss_code;
        logic       blocking;
    } hdr_codes_t;

    // values decoded from the codes
    typedef struct packed {
        logic [16:0] blk_len;
        logic [19:0] rate_hz;
        logic [5:0]  sample_bits;
    } dec_values_t;

    // one result item
    typedef struct packed {
        logic        header_ok;
        logic [2:0]  error_code;
        logic [4:0]  header_length;
        logic        var_blocking;
        logic [3:0]  chan_code;
        logic [20:0] frame_num;
        logic [16:0] blk_len;
        logic [19:0] rate_hz;
        logic [5:0]  sample_bits;
        logic [7:0]  header_crc;
    } result_t;

    // crc-8, polynomial 0x07, msb first
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ((c << 1) ^ 8'h07) : (c << 1);
        end
        return c;
    endfunction

    // standard sample rate table
    function automatic logic [19:0] rate_lookup(input logic [3:0] code);
        logic [19:0] r;
        case (code)
            4'd1:    r = 20'd88200;
            4'd2:    r = 20'd176400;
            4'd3:    r = 20'd192000;
            4'd4:    r = 20'd8000;
            4'd5:    r = 20'd16000;
            4'd6:    r = 20'd22050;
            4'd7:    r = 20'd24000;
            4'd8:    r = 20'd32000;
            4'd9:    r = 20'd44100;
            4'd10:   r = 20'd48000;
            4'd11:   r = 20'd96000;
            default: r = 20'd0;
        endcase
        return r;
    endfunction

    // sample size table, code 3 reserved
    function automatic logic [5:0] size_lookup(input logic [2:0] code);
        logic [5:0] s;
        case (code)
            3'd1:    s = 6'd8;
            3'd2:    s = 6'd12;
            3'd4:    s = 6'd16;
            3'd5:    s = 6'd20;
            3'd6:    s = 6'd24;
            3'd7:    s = 6'd32;
            default: s = 6'd0;
        endcase
        return s;
    endfunction

endpackage

### rtl/fhp_byte_if.sv
// ----------------------------------------------------------------------------
// fhp_byte_if
// Byte channel into the parser: one header byte with its framing flags.
// ----------------------------------------------------------------------------
interface fhp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       start_header;
    logic       final_byte;

    modport source (output valid, output data_byte, output start_header,
                    output final_byte, input ready);
    modport sink   (input valid, input data_byte, input start_header,
                    input final_byte, output ready);
endinterface

### rtl/fhp_result_if.sv
// ----------------------------------------------------------------------------
// fhp_result_if
// Result channel out of the parser: one parsed header or error item.
// ----------------------------------------------------------------------------
interface fhp_result_if;
    logic        valid;
    logic        ready;
    logic        header_ok;
    logic [2:0]  error_code;
    logic [4:0]  header_length;
    logic        var_blocking;
    logic [3:0]  chan_code;
    logic [20:0] frame_num;
    logic [16:0] blk_len;
    logic [19:0] rate_hz;
    logic [5:0]  sample_bits;
    logic [7:0]  header_crc;

    modport source (output valid, output header_ok, output error_code,
                    output header_length, output var_blocking,
                    output chan_code, output frame_num,
                    output blk_len, output rate_hz, output sample_bits,
                    output header_crc, input ready);
    modport sink   (input valid, input header_ok, input error_code,
                    input header_length, input var_blocking,
                    input chan_code, input frame_num,
                    input blk_len, input rate_hz, input sample_bits,
                    input header_crc, output ready);
endinterface

### rtl/flac_frame_header_parser_core.sv
// ----------------------------------------------------------------------------
// flac_frame_header_parser_core
// Byte-serial frame header parser with crc-8 check and one result per header.
// ----------------------------------------------------------------------------
// Throughput: one byte item per cycle while the output register is empty or
//   drained in the same cycle; a result held by a stalled receiver stalls input.
// A result is registered and valid in the cycle after the byte that closes the header.
// The per-byte crc-8 step and field capture sit between the parse state and
//   the result register.
// Reset: asynchronous, clears parse state, configuration and output valid.
// ----------------------------------------------------------------------------
module flac_frame_header_parser_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [fhp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [fhp_pkg::CFG_DATA_W-1:0]  cfg_data,
    fhp_byte_if.sink                     byte_in,
    fhp_result_if.source                 result_out
);
    import fhp_pkg::*;

    typedef enum logic [6:0] {
        PH_IDLE  = 7'b0000001,
        PH_FIXED = 7'b0000010,
        PH_NUM   = 7'b0000100,
        PH_NUMC  = 7'b0001000,
        PH_BSX   = 7'b0010000,
        PH_SRX   = 7'b0100000,
        PH_CRC   = 7'b1000000
    } phase_t;

    // configuration registers
    logic [19:0] stream_rate_reg;
    logic [5:0]  stream_bps_reg;

    // parse state
    phase_t      phase_reg,  phase_next;
    logic [3:0]  pos_reg,    pos_next;
    logic [7:0]  crc_reg,    crc_next;
    logic [1:0]  left_reg,   left_next;
    logic [20:0] num_reg,    num_next;
    hdr_codes_t  codes_reg,  codes_next;
    logic [15:0] ev_reg,     ev_next;
    logic [15:0] er_reg,     er_next;
    logic [1:0]  extra_reg,  extra_next;

    // effective state for this byte (cleared on start)
    phase_t      c_phase;
    logic [3:0]  c_pos;
    logic [7:0]  c_crc;
    logic [1:0]  c_left;
    logic [20:0] c_num;
    hdr_codes_t  c_codes;
    logic [15:0] c_ev;
    logic [15:0] c_er;
    logic [1:0]  c_extra;

    logic        out_valid_reg;
    result_t     res_reg, res_next;
    dec_values_t dec;

    logic [7:0]  b;
    logic        accept;
    logic        active;
    logic        fire;
    logic        res_fire;
    logic        done;
    logic [2:0]  err;
    phase_t      rate_phase;
    logic [1:0]  rate_extra;
    phase_t      num_phase;
    logic [1:0]  num_extra;

    assign b      = byte_in.data_byte;
    assign accept = byte_in.valid && byte_in.ready;
    assign active = byte_in.start_header || (phase_reg != PH_IDLE);
    assign fire   = accept && active;

    // input is free whenever the output slot is empty or being drained
    assign byte_in.ready = !out_valid_reg || result_out.ready;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stream_rate_reg <= 20'd0;
            stream_bps_reg  <= 6'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_STREAM_RATE:            stream_rate_reg <= cfg_data[19:0];
                CFG_STREAM_BITS_PER_SAMPLE: stream_bps_reg  <= cfg_data[5:0];
                default:                    ;
            endcase
        end
    end

    // start of header restarts from a clean state
    always_comb
    begin
        if (byte_in.start_header)
        begin
            c_phase = PH_FIXED;
            c_pos   = 4'd0;
            c_crc   = 8'd0;
            c_left  = 2'd0;
            c_num   = 21'd0;
            c_codes = '0;
            c_ev    = 16'd0;
            c_er    = 16'd0;
            c_extra = 2'd0;
        end
        else
        begin
            c_phase = phase_reg;
            c_pos   = pos_reg;
            c_crc   = crc_reg;
            c_left  = left_reg;
            c_num   = num_reg;
            c_codes = codes_reg;
            c_ev    = ev_reg;
            c_er    = er_reg;
            c_extra = extra_reg;
        end
    end

    // phase after the explicit block size bytes
    always_comb
    begin
        if (c_codes.sr_code == 4'd12)
        begin
            rate_phase = PH_SRX;
            rate_extra = 2'd1;
        end
        else if (c_codes.sr_code == 4'd13 || c_codes.sr_code == 4'd14)
        begin
            rate_phase = PH_SRX;
            rate_extra = 2'd2;
        end
        else
        begin
            rate_phase = PH_CRC;
            rate_extra = c_extra;
        end
    end

    // phase after the frame number
    always_comb
    begin
        if (c_codes.bs_code == 4'd6)
        begin
            num_phase = PH_BSX;
            num_extra = 2'd1;
        end
        else if (c_codes.bs_code == 4'd7)
        begin
            num_phase = PH_BSX;
            num_extra = 2'd2;
        end
        else
        begin
            num_phase = rate_phase;
            num_extra = rate_extra;
        end
    end

    // per-byte parse step
    always_comb
    begin
        phase_next = c_phase;
        pos_next   = c_pos;
        crc_next   = c_crc;
        left_next  = c_left;
        num_next   = c_num;
        codes_next = c_codes;
        ev_next    = c_ev;
        er_next    = c_er;
        extra_next = c_extra;
        err        = ERR_NONE;
        done       = 1'b0;

        unique case (c_phase)
            PH_IDLE:
            begin
            end
            PH_FIXED:
            begin
                if (c_pos == 4'd0)
                begin
                    if (b != 8'hFF)
                    begin
                        err = ERR_SYNC;
                    end
                end
                else if (c_pos == 4'd1)
                begin
                    if (b[7:2] != 6'b111110)
                    begin
                        err = ERR_SYNC;
                    end
                    else
                    begin
                        codes_next.blocking = b[0];
                    end
                end
                else if (c_pos == 4'd2)
                begin
                    codes_next.bs_code = b[7:4];
                    codes_next.sr_code = b[3:0];
                    if (b[7:4] == 4'd0)
                    begin
                        err = ERR_RSV_BS;
                    end
                    else if (b[3:0] == 4'hF)
                    begin
                        err = ERR_RSV_RATE;
                    end
                end
                else
                begin
                    codes_next.chan    = b[7:4];
                    codes_next.ss_code = b[3:1];
                    phase_next         = PH_NUM;
                end
            end
            PH_NUM:
            begin
                if (!b[7])
                begin
                    num_next   = {13'd0, b};
                    phase_next = num_phase;
                    extra_next = num_extra;
                end
                else if (b[7:5] == 3'b110)
                begin
                    num_next   = {16'd0, b[4:0]};
                    left_next  = 2'd1;
                    phase_next = PH_NUMC;
                end
                else if (b[7:4] == 4'b1110)
                begin
                    num_next   = {17'd0, b[3:0]};
                    left_next  = 2'd2;
                    phase_next = PH_NUMC;
                end
                else if (b[7:3] == 5'b11110)
                begin
                    num_next   = {18'd0, b[2:0]};
                    left_next  = 2'd3;
                    phase_next = PH_NUMC;
                end
                else
                begin
                    err = ERR_UTF8;
                end
            end
            PH_NUMC:
            begin
                if (b[7:6] != 2'b10)
                begin
                    err = ERR_UTF8;
                end
                else
                begin
                    num_next  = {c_num[14:0], b[5:0]};
                    left_next = c_left - 2'd1;
                    if (c_left == 2'd1)
                    begin
                        phase_next = num_phase;
                        extra_next = num_extra;
                    end
                end
            end
            PH_BSX:
            begin
                ev_next    = {c_ev[7:0], b};
                extra_next = c_extra - 2'd1;
                if (c_extra == 2'd1)
                begin
                    phase_next = rate_phase;
                    extra_next = rate_extra;
                end
            end
            PH_SRX:
            begin
                er_next    = {c_er[7:0], b};
                extra_next = c_extra - 2'd1;
                if (c_extra == 2'd1)
                begin
                    phase_next = PH_CRC;
                end
            end
            PH_CRC:
            begin
                if (b == c_crc)
                begin
                    done = 1'b1;
                end
                else
                begin
                    err = ERR_CRC;
                end
            end
            default:
            begin
            end
        endcase

        // data ran out before the header closed
        if (!done && err == ERR_NONE && byte_in.final_byte)
        begin
            err = ERR_TRUNC;
        end

        if (done || err != ERR_NONE)
        begin
            phase_next = PH_IDLE;
        end
        else
        begin
            crc_next = crc8_step(c_crc, b);
            pos_next = c_pos + 4'd1;
        end
    end

    assign res_fire = fire && (done || err != ERR_NONE);

    // code tables, fed from the held state (stable during the crc byte)
    fhp_field_decode u_decode (
        .codes                  (codes_reg),
        .explicit_bs            (ev_reg),
        .explicit_rate          (er_reg),
        .stream_rate            (stream_rate_reg),
        .stream_bits_per_sample (stream_bps_reg),
        .values                 (dec)
    );

    // result item
    always_comb
    begin
        res_next = '0;
        if (done)
        begin
            res_next.header_ok     = 1'b1;
            res_next.header_length = {1'b0, c_pos} + 5'd1;
            res_next.var_blocking  = c_codes.blocking;
            res_next.chan_code     = c_codes.chan;
            res_next.frame_num     = c_num;
            res_next.blk_len       = dec.blk_len;
            res_next.rate_hz       = dec.rate_hz;
            res_next.sample_bits   = dec.sample_bits;
            res_next.header_crc    = b;
        end
        else
        begin
            res_next.error_code = err;
        end
    end

    // parse state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            pos_reg   <= 4'd0;
            crc_reg   <= 8'd0;
            left_reg  <= 2'd0;
            num_reg   <= 21'd0;
            codes_reg <= '0;
            ev_reg    <= 16'd0;
            er_reg    <= 16'd0;
            extra_reg <= 2'd0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            crc_reg   <= crc_next;
            left_reg  <= left_next;
            num_reg   <= num_next;
            codes_reg <= codes_next;
            ev_reg    <= ev_next;
            er_reg    <= er_next;
            extra_reg <= extra_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_fire)
        begin
            res_reg <= res_next;
        end
    end

    assign result_out.valid         = out_valid_reg;
    assign result_out.header_ok     = res_reg.header_ok;
    assign result_out.error_code    = res_reg.error_code;
    assign result_out.header_length = res_reg.header_length;
    assign result_out.var_blocking  = res_reg.var_blocking;
    assign result_out.chan_code     = res_reg.chan_code;
    assign result_out.frame_num     = res_reg.frame_num;
    assign result_out.blk_len       = res_reg.blk_len;
    assign result_out.rate_hz       = res_reg.rate_hz;
    assign result_out.sample_bits   = res_reg.sample_bits;
    assign result_out.header_crc    = res_reg.header_crc;

`ifndef NO_ASSERTIONS
    // a result always returns the parser to idle
    a_idle_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        res_fire |=> phase_reg == PH_IDLE)
        else $error("parser not idle after result");

    // ok and error code are exclusive on every result
    a_ok_xor_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (res_reg.header_ok == (res_reg.error_code == ERR_NONE)))
        else $error("header_ok and error_code disagree");

    // a good header has at least sync, codes, one number byte and crc
    a_min_length: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.header_ok) |-> res_reg.header_length >= 5'd6)
        else $error("good header shorter than six bytes");

    // error items carry no length
    a_err_no_length: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !res_reg.header_ok) |-> res_reg.header_length == 5'd0)
        else $error("error item with nonzero length");
`endif

endmodule

### rtl/fhp_field_decode.sv
// ----------------------------------------------------------------------------
// fhp_field_decode
// Maps block size, sample rate and sample size codes to their values.
// ----------------------------------------------------------------------------
module fhp_field_decode (
    input  fhp_pkg::hdr_codes_t  codes,
    input  logic [15:0]          explicit_bs,
    input  logic [15:0]          explicit_rate,
    input  logic [19:0]          stream_rate,
    input  logic [5:0]           stream_bits_per_sample,
    output fhp_pkg::dec_values_t values
);
    import fhp_pkg::*;

    // block size
    always_comb
    begin
        case (codes.bs_code) inside
            4'd1:
                values.blk_len = 17'd192;
            // 2..5 give 576 shifted by code-2; flipping bit 1 yields that shift
            [4'd2:4'd5]:
                values.blk_len = 17'd576 << (codes.bs_code[1:0] ^ 2'b10);
            4'd6, 4'd7:
                values.blk_len = {1'b0, explicit_bs} + 17'd1;
            [4'd8:4'd15]:
                values.blk_len = 17'd256 << codes.bs_code[2:0];
            default:
                values.blk_len = 17'd0;
        endcase
    end

    // sample rate
    always_comb
    begin
        case (codes.sr_code)
            4'd0:    values.rate_hz = stream_rate;
            4'd12:   values.rate_hz = 20'(explicit_rate[7:0]) * 20'd1000;
            4'd13:   values.rate_hz = 20'(explicit_rate);
            4'd14:   values.rate_hz = 20'(explicit_rate) * 20'd10;
            default: values.rate_hz = rate_lookup(codes.sr_code);
        endcase
    end

    // sample size
    always_comb
    begin
        if (codes.ss_code == 3'd0)
        begin
            values.sample_bits = stream_bits_per_sample;
        end
        else
        begin
            values.sample_bits = size_lookup(codes.ss_code);
        end
    end

endmodule
